@@ rtl/wpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// World point screen projection package
// Shared fixed-point constants, register indexes and the payload types of the
// input and result channels.
// ----------------------------------------------------------------------------
package wpsp_pkg;

  // Number of fraction bits in the QxF matrix entries and world coordinates.
  localparam int FRAC_BITS = 16;

  // Smallest clip w that counts as visible: ceil(0.001 * 2^FRAC_BITS).
  localparam longint W_MIN = ((longint'(1) << FRAC_BITS) + 999) / 1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SCREEN_W   = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HT = 3'd7;

  localparam logic [SCREEN_W-1:0] SCREEN_WD_RST = 14'd1920;
  localparam logic [SCREEN_W-1:0] SCREEN_HT_RST = 14'd1080;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } out_item_t;

endpackage

@@ rtl/world_point_screen_projection_core.sv @@
// ----------------------------------------------------------------------------
// World point screen projection core
// Projects a world point through three rows of a world-to-screen matrix,
// tests clip w, divides by w and maps the result to saturated pixel values.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Direction | Contents
//  --------+--------------------------------+-----------+---------------------
//  input   | in_valid, in_stall, in_data    | in        | world x, y, z
//  result  | out_valid, out_stall, out_data | out       | visible, column, row
//  config  | cfg_we, cfg_index, cfg_wdata   | in        | matrix rows, screen
//
// One point is taken in every cycle while in_stall is low. The divider
// resolves one quotient bit per stage over 17 stages after an absolute-value
// stage and an overflow stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults (zero matrix, 1920 by 1080 screen).
// Each stage holds its item until the stage after it is free, so bubbles are
// squeezed out and a stall at the output reaches the input only once every
// stage is full.
// ----------------------------------------------------------------------------
module world_point_screen_projection_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wpsp_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wpsp_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [wpsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wpsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wpsp_pkg::*;

  // Stage map: 0 products, 1 clip values, 2 viewport products, 3 numerators,
  // 4 .. 22 divider, 23 result register.
  localparam int DIV_ST = 19;
  localparam int NST    = 4 + DIV_ST + 1;
  localparam int RW     = 50;
  localparam int QW     = 17;

  typedef struct packed {
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          ovfx;
    logic          ovfy;
    logic          negx;
    logic          negy;
    logic [32:0]   den;
    logic          vis;
  } div_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] row_r [6];
  logic [SCREEN_W-1:0]   wd_r;
  logic [SCREEN_W-1:0]   ht_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) row_r[i] <= '0;
      wd_r <= SCREEN_WD_RST;
      ht_r <= SCREEN_HT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0_A:    row_r[0] <= cfg_wdata;
        REG_ROW0_B:    row_r[1] <= cfg_wdata;
        REG_ROW1_A:    row_r[2] <= cfg_wdata;
        REG_ROW1_B:    row_r[3] <= cfg_wdata;
        REG_ROW3_A:    row_r[4] <= cfg_wdata;
        REG_ROW3_B:    row_r[5] <= cfg_wdata;
        REG_SCREEN_WD: wd_r <= cfg_wdata[SCREEN_W-1:0];
        REG_SCREEN_HT: ht_r <= cfg_wdata[SCREEN_W-1:0];
        default:       wd_r <= wd_r;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its item moves on.
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic [NST-1:0] v_in;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST-2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign v_in     = {v_r[NST-2:0], in_valid};
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en & v_in) | (~en & v_r);
    end
  end

  // Stage 0: the nine matrix-by-coordinate products.
  logic signed [63:0] s0_prod_r [3][3];
  logic signed [63:0] s0_prod_nxt [3][3];
  logic signed [31:0] pt [3];

  always_comb begin
    pt[0] = in_data.world_x;
    pt[1] = in_data.world_y;
    pt[2] = in_data.world_z;
    for (int r = 0; r < 3; r++) begin
      s0_prod_nxt[r][0] = signed'(row_r[2*r][63:32]) * pt[0];
      s0_prod_nxt[r][1] = signed'(row_r[2*r][31:0])  * pt[1];
      s0_prod_nxt[r][2] = signed'(row_r[2*r+1][63:32]) * pt[2];
    end
  end

  // Stage 1: floor-shifted sum plus translation, saturated to 32 bits.
  logic signed [31:0] s1_clip_r [3];
  logic signed [31:0] s1_clip_nxt [3];
  logic signed [65:0] acc [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(s0_prod_r[r][0] >>> FRAC_BITS)
             + 66'(s0_prod_r[r][1] >>> FRAC_BITS)
             + 66'(s0_prod_r[r][2] >>> FRAC_BITS)
             + 66'(signed'(row_r[2*r+1][31:0]));
      if (acc[r] > 66'sd2147483647) begin
        s1_clip_nxt[r] = 32'sh7fffffff;
      end else if (acc[r] < -66'sd2147483648) begin
        s1_clip_nxt[r] = 32'sh80000000;
      end else begin
        s1_clip_nxt[r] = acc[r][31:0];
      end
    end
  end

  // Stage 2: viewport products and the visibility test.
  logic signed [46:0] s2_mx_r, s2_my_r, s2_mw_r, s2_mh_r;
  logic signed [46:0] s2_mx_nxt, s2_my_nxt, s2_mw_nxt, s2_mh_nxt;
  logic signed [31:0] s2_w_r;
  logic               s2_vis_r, s2_vis_nxt;
  logic signed [14:0] wds, hts, wdh, hth;

  always_comb begin
    wds        = signed'({1'b0, wd_r});
    hts        = signed'({1'b0, ht_r});
    wdh        = signed'({2'b00, wd_r[SCREEN_W-1:1]});
    hth        = signed'({2'b00, ht_r[SCREEN_W-1:1]});
    s2_mx_nxt  = s1_clip_r[0] * wds;
    s2_my_nxt  = s1_clip_r[1] * hts;
    s2_mw_nxt  = s1_clip_r[2] * wdh;
    s2_mh_nxt  = s1_clip_r[2] * hth;
    s2_vis_nxt = 64'(s1_clip_r[2]) >= 64'(W_MIN);
  end

  // Stage 3: numerators over the denominator 2w.
  logic signed [RW-1:0] s3_nx_r, s3_ny_r, s3_nx_nxt, s3_ny_nxt;
  logic [32:0]          s3_den_r;
  logic                 s3_vis_r;

  always_comb begin
    s3_nx_nxt = (RW'(s2_mw_r) <<< 1) + RW'(s2_mx_r) + RW'(s2_w_r);
    s3_ny_nxt = (RW'(s2_mh_r) <<< 1) - RW'(s2_my_r) - RW'(s2_w_r);
  end

  // Divider: absolute value, overflow test, then one quotient bit per stage.
  div_t d_r   [DIV_ST];
  div_t d_nxt [DIV_ST];
  logic [RW-1:0] dsh;

  always_comb begin
    dsh = '0;
    d_nxt[0]      = '0;
    d_nxt[0].negx = s3_nx_r[RW-1];
    d_nxt[0].negy = s3_ny_r[RW-1];
    d_nxt[0].rx   = s3_nx_r[RW-1] ? RW'(-s3_nx_r) : RW'(s3_nx_r);
    d_nxt[0].ry   = s3_ny_r[RW-1] ? RW'(-s3_ny_r) : RW'(s3_ny_r);
    d_nxt[0].den  = s3_den_r;
    d_nxt[0].vis  = s3_vis_r;

    d_nxt[1]      = d_r[0];
    d_nxt[1].ovfx = d_r[0].rx >= (RW'(d_r[0].den) << QW);
    d_nxt[1].ovfy = d_r[0].ry >= (RW'(d_r[0].den) << QW);

    for (int j = 2; j < DIV_ST; j++) begin
      d_nxt[j] = d_r[j-1];
      dsh      = RW'(d_r[j-1].den) << (DIV_ST - 1 - j);
      if (d_r[j-1].rx >= dsh) begin
        d_nxt[j].rx                   = d_r[j-1].rx - dsh;
        d_nxt[j].qx[DIV_ST - 1 - j]   = 1'b1;
      end
      if (d_r[j-1].ry >= dsh) begin
        d_nxt[j].ry                   = d_r[j-1].ry - dsh;
        d_nxt[j].qy[DIV_ST - 1 - j]   = 1'b1;
      end
    end
  end

  // Result stage: sign, saturation to 16 bits, zero when not visible.
  out_item_t out_r, out_nxt;
  div_t      df;

  function automatic logic signed [15:0] wpsp_sat(input logic neg, input logic ovf,
                                                   input logic [QW-1:0] q);
    logic signed [15:0] res;
    if (!neg) begin
      res = (ovf || q > 17'd32767) ? 16'sh7fff : signed'(q[15:0]);
    end else begin
      res = (ovf || q > 17'd32768) ? 16'sh8000 : signed'(16'(17'd0 - q));
    end
    return res;
  endfunction

  always_comb begin
    df               = d_r[DIV_ST-1];
    out_nxt.visible  = df.vis;
    out_nxt.screen_x = df.vis ? wpsp_sat(df.negx, df.ovfx, df.qx) : 16'sd0;
    out_nxt.screen_y = df.vis ? wpsp_sat(df.negy, df.ovfy, df.qy) : 16'sd0;
  end

  // Payload registers, each loaded with its stage's enable.
  always_ff @(posedge clk) begin
    if (en[0]) s0_prod_r <= s0_prod_nxt;
    if (en[1]) s1_clip_r <= s1_clip_nxt;
    if (en[2]) begin
      s2_mx_r  <= s2_mx_nxt;
      s2_my_r  <= s2_my_nxt;
      s2_mw_r  <= s2_mw_nxt;
      s2_mh_r  <= s2_mh_nxt;
      s2_w_r   <= s1_clip_r[2];
      s2_vis_r <= s2_vis_nxt;
    end
    if (en[3]) begin
      s3_nx_r  <= s3_nx_nxt;
      s3_ny_r  <= s3_ny_nxt;
      s3_den_r <= {s2_w_r, 1'b0};
      s3_vis_r <= s2_vis_r;
    end
    for (int j = 0; j < DIV_ST; j++) begin
      if (en[4+j]) d_r[j] <= d_nxt[j];
    end
    if (en[NST-1]) out_r <= out_nxt;
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

endmodule
